[rtl/mps_pkg.sv]
// ----------------------------------------------------------------------------
// mps_pkg
// Shared types, constants and arithmetic for the minimum prefix sum tree.
// ----------------------------------------------------------------------------
package mps_pkg;

    localparam int MAX_ELEMENTS = 1024;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int ROW_W        = IDX_W - 1;
    localparam int ROWS         = MAX_ELEMENTS / 2;
    localparam int CNT_W        = IDX_W + 1;
    localparam int VAL_W        = 40;
    localparam int ADD_W        = 24;
    localparam int FUNC_W       = 2;

    localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_MARK  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd2;

    typedef logic signed [VAL_W-1:0] val_t;

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam val_t INF_VAL = VAL_MAX;

    // one tree node: range sum and minimum prefix sum
    typedef struct packed {
        val_t sum;
        val_t min_pfx;
    } node_t;

    // one leaf as stored: element value and right-end flag
    typedef struct packed {
        logic mark;
        val_t sum;
    } leaf_t;

    // request to the node store: one read row, per-half writes
    typedef struct packed {
        logic [ROW_W-1:0] rd_row;
        logic [ROW_W-1:0] int_wr_row;
        logic [1:0]       int_wr_en;
        node_t            int_wr_data;
        logic [ROW_W-1:0] leaf_wr_row;
        logic [1:0]       leaf_wr_en;
        leaf_t            leaf_wr_data;
    } mem_req_t;

    // registered read data: both children of the addressed node
    typedef struct packed {
        node_t int_l;
        node_t int_r;
        leaf_t leaf_l;
        leaf_t leaf_r;
    } mem_rsp_t;

    function automatic val_t sat_add(val_t a, val_t b);
        logic signed [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

    function automatic node_t combine(node_t l, node_t r);
        node_t p;
        val_t  cand;
        p.sum = sat_add(l.sum, r.sum);
        // an empty right side stays empty
        cand = (r.min_pfx == INF_VAL) ? INF_VAL : sat_add(l.sum, r.min_pfx);
        p.min_pfx = (l.min_pfx < cand) ? l.min_pfx : cand;
        return p;
    endfunction

    function automatic node_t leaf_node(leaf_t lf, logic [IDX_W-1:0] j,
                                        logic [CNT_W-1:0] cnt);
        node_t n;
        n.sum = lf.sum;
        n.min_pfx = (lf.mark && ({1'b0, j} < cnt)) ? lf.sum : INF_VAL;
        return n;
    endfunction

endpackage

[rtl/mps_tree_mem.sv]
// ----------------------------------------------------------------------------
// mps_tree_mem
// Node store: sibling pairs of internal nodes and of leaves, one row per
// parent, split in left and right halves with their own write enables.
// ----------------------------------------------------------------------------
module mps_tree_mem (
    input  logic               aclk,
    input  mps_pkg::mem_req_t  req,
    output mps_pkg::mem_rsp_t  rsp
);

    mps_pkg::node_t int_l_mem  [mps_pkg::ROWS];
    mps_pkg::node_t int_r_mem  [mps_pkg::ROWS];
    mps_pkg::leaf_t leaf_l_mem [mps_pkg::ROWS];
    mps_pkg::leaf_t leaf_r_mem [mps_pkg::ROWS];

    mps_pkg::mem_rsp_t rsp_reg;

    always_ff @(posedge aclk) begin
        if (req.int_wr_en[0]) begin
            int_l_mem[req.int_wr_row] <= req.int_wr_data;
        end
        if (req.int_wr_en[1]) begin
            int_r_mem[req.int_wr_row] <= req.int_wr_data;
        end
        if (req.leaf_wr_en[0]) begin
            leaf_l_mem[req.leaf_wr_row] <= req.leaf_wr_data;
        end
        if (req.leaf_wr_en[1]) begin
            leaf_r_mem[req.leaf_wr_row] <= req.leaf_wr_data;
        end
        rsp_reg.int_l  <= int_l_mem[req.rd_row];
        rsp_reg.int_r  <= int_r_mem[req.rd_row];
        rsp_reg.leaf_l <= leaf_l_mem[req.rd_row];
        rsp_reg.leaf_r <= leaf_r_mem[req.rd_row];
    end

    assign rsp = rsp_reg;

endmodule

[rtl/min_prefix_sum_tree_top.sv]
// ----------------------------------------------------------------------------
// min_prefix_sum_tree_top
// Segment tree of range sums and minimum prefix sums over 1024 elements.
//
// Input beats (s_valid/s_ready) clear the tree, set or clear a right-end
// mark or add a signed value to one element; every beat returns one result
// beat (m_valid/m_ready) with the global minimum prefix sum and its location.
// One shared combine unit (two saturating adds and a compare) walks the
// leaf-to-root path one level a cycle, then the root-to-leaf search runs
// one level a cycle through the registered node store.
// Mark and add: the leaf update, the path walk, the search and the output
// step follow in that order, and no new input beat is taken before the
// result is in the output register. An index outside the element count, or
// func 3, runs only the search and the output step. Clear: row sweep plus
// the search. The block is busy for the whole item.
// A write to element_count rebuilds every internal node, with s_ready low
// meanwhile.
// After reset a clearing sweep of every row runs before s_ready rises.
// A result waits in the output register while m_ready is low; the next
// input beat is still taken, and its result waits for the register.
// ----------------------------------------------------------------------------
module min_prefix_sum_tree_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [mps_pkg::CNT_W-1:0]         cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [mps_pkg::FUNC_W-1:0]        s_func,
    input  logic [mps_pkg::IDX_W-1:0]         s_element_index,
    input  logic                              s_mark_right_end,
    input  logic signed [mps_pkg::ADD_W-1:0]  s_add_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [mps_pkg::VAL_W-1:0]  m_min_prefix,
    output logic [mps_pkg::IDX_W-1:0]         m_min_location,
    output logic                              m_none_marked
);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_LEAF,
        S_UP0,
        S_UP,
        S_DN0,
        S_DN,
        S_RES,
        S_RB,
        S_RB_GAP
    } state_t;

    localparam int IDX_W = mps_pkg::IDX_W;
    localparam int ROW_W = mps_pkg::ROW_W;
    localparam int CNT_W = mps_pkg::CNT_W;
    localparam int VAL_W = mps_pkg::VAL_W;
    localparam int ADD_W = mps_pkg::ADD_W;

    // control
    state_t             state_reg,    state_next;
    logic [ROW_W-1:0]   clr_row_reg,  clr_row_next;
    logic               clr_item_reg, clr_item_next;
    logic               pend_reg,     pend_next;
    logic [CNT_W-1:0]   count_reg,    count_next;
    logic               m_valid_reg,  m_valid_next;

    // datapath
    logic [IDX_W-1:0]   node_idx_reg, node_idx_next;
    logic [IDX_W-1:0]   rd_node_reg,  rd_node_next;
    logic [IDX_W-1:0]   idx_reg,      idx_next;
    logic               op_add_reg,   op_add_next;
    logic               mark_reg,     mark_next;
    logic signed [ADD_W-1:0] val_reg, val_next;
    mps_pkg::node_t     kids_l_reg,   kids_l_next;
    mps_pkg::node_t     kids_r_reg,   kids_r_next;
    mps_pkg::node_t     node_val_reg, node_val_next;
    mps_pkg::val_t      root_min_reg, root_min_next;
    mps_pkg::val_t      cur_min_reg,  cur_min_next;
    logic [IDX_W-1:0]   loc_reg,      loc_next;
    mps_pkg::val_t      m_min_prefix_reg,   m_min_prefix_next;
    logic [IDX_W-1:0]   m_min_location_reg, m_min_location_next;
    logic               m_none_marked_reg,  m_none_marked_next;

    mps_pkg::mem_req_t  mem_req;
    mps_pkg::mem_rsp_t  mem_rsp;

    mps_pkg::node_t     rd_kid_l, rd_kid_r;
    mps_pkg::node_t     sub_l, sub_r;
    mps_pkg::node_t     cmb_l, cmb_r, cmb_out;
    mps_pkg::leaf_t     lf_old, lf_new, leaf_l_upd, leaf_r_upd;
    mps_pkg::val_t      add_ext;
    logic               dir;
    logic [IDX_W-1:0]   leaf_j;
    logic [CNT_W-1:0]   count_m1;
    logic               in_range;

    mps_tree_mem u_mem (
        .aclk (aclk),
        .req  (mem_req),
        .rsp  (mem_rsp)
    );

    // children of the node whose row was read last
    always_comb begin
        if (rd_node_reg[IDX_W-1]) begin
            rd_kid_l = mps_pkg::leaf_node(mem_rsp.leaf_l,
                                          {rd_node_reg[ROW_W-1:0], 1'b0}, count_reg);
            rd_kid_r = mps_pkg::leaf_node(mem_rsp.leaf_r,
                                          {rd_node_reg[ROW_W-1:0], 1'b1}, count_reg);
        end else begin
            rd_kid_l = mem_rsp.int_l;
            rd_kid_r = mem_rsp.int_r;
        end
    end

    // path walk: the freshly computed child replaces its stored copy
    always_comb begin
        sub_l = node_idx_reg[0] ? mem_rsp.int_l : node_val_reg;
        sub_r = node_idx_reg[0] ? node_val_reg  : mem_rsp.int_r;
    end

    // shared combine unit
    always_comb begin
        case (state_reg)
            S_UP0: begin
                cmb_l = kids_l_reg;
                cmb_r = kids_r_reg;
            end
            S_UP: begin
                cmb_l = sub_l;
                cmb_r = sub_r;
            end
            default: begin
                cmb_l = rd_kid_l;
                cmb_r = rd_kid_r;
            end
        endcase
        cmb_out = mps_pkg::combine(cmb_l, cmb_r);
    end

    // leaf update
    always_comb begin
        add_ext = {{(VAL_W-ADD_W){val_reg[ADD_W-1]}}, val_reg};
        lf_old  = idx_reg[0] ? mem_rsp.leaf_r : mem_rsp.leaf_l;
        lf_new  = lf_old;
        if (op_add_reg) begin
            lf_new.sum = mps_pkg::sat_add(lf_old.sum, add_ext);
        end else begin
            lf_new.mark = mark_reg;
        end
        leaf_l_upd = idx_reg[0] ? mem_rsp.leaf_l : lf_new;
        leaf_r_upd = idx_reg[0] ? lf_new : mem_rsp.leaf_r;
    end

    always_comb begin
        dir      = (cur_min_reg != rd_kid_l.min_pfx);
        leaf_j   = {rd_node_reg[ROW_W-1:0], dir};
        count_m1 = count_reg - 1'b1;
        in_range = ({1'b0, s_element_index} < count_reg);
    end

    always_comb begin
        state_next          = state_reg;
        clr_row_next        = clr_row_reg;
        clr_item_next       = clr_item_reg;
        pend_next           = pend_reg | cfg_wr_en;
        count_next          = count_reg;
        m_valid_next        = m_valid_reg & ~m_ready;
        node_idx_next       = node_idx_reg;
        rd_node_next        = rd_node_reg;
        idx_next            = idx_reg;
        op_add_next         = op_add_reg;
        mark_next           = mark_reg;
        val_next            = val_reg;
        kids_l_next         = kids_l_reg;
        kids_r_next         = kids_r_reg;
        node_val_next       = node_val_reg;
        root_min_next       = root_min_reg;
        cur_min_next        = cur_min_reg;
        loc_next            = loc_reg;
        m_min_prefix_next   = m_min_prefix_reg;
        m_min_location_next = m_min_location_reg;
        m_none_marked_next  = m_none_marked_reg;

        mem_req.int_wr_row          = node_idx_reg[IDX_W-1:1];
        mem_req.int_wr_en           = 2'b00;
        mem_req.int_wr_data         = node_val_reg;
        mem_req.leaf_wr_row         = idx_reg[IDX_W-1:1];
        mem_req.leaf_wr_en          = 2'b00;
        mem_req.leaf_wr_data        = lf_new;

        if (cfg_wr_en) begin
            if (cfg_wr_data == '0) begin
                count_next = CNT_W'(1);
            end else if (cfg_wr_data > CNT_W'(mps_pkg::MAX_ELEMENTS)) begin
                count_next = CNT_W'(mps_pkg::MAX_ELEMENTS);
            end else begin
                count_next = cfg_wr_data;
            end
        end

        case (state_reg)
            S_CLR: begin
                mem_req.int_wr_row          = clr_row_reg;
                mem_req.int_wr_en           = 2'b11;
                mem_req.int_wr_data.sum     = '0;
                mem_req.int_wr_data.min_pfx = mps_pkg::INF_VAL;
                mem_req.leaf_wr_row         = clr_row_reg;
                mem_req.leaf_wr_en          = 2'b11;
                mem_req.leaf_wr_data.mark   = 1'b0;
                mem_req.leaf_wr_data.sum    = '0;
                if (clr_row_reg == ROW_W'(mps_pkg::ROWS - 1)) begin
                    root_min_next = mps_pkg::INF_VAL;
                    state_next    = clr_item_reg ? S_DN0 : S_IDLE;
                end else begin
                    clr_row_next = clr_row_reg + 1'b1;
                end
            end
            S_IDLE: begin
                if (pend_reg) begin
                    pend_next     = cfg_wr_en;
                    node_idx_next = IDX_W'(mps_pkg::MAX_ELEMENTS - 1);
                    rd_node_next  = IDX_W'(mps_pkg::MAX_ELEMENTS - 1);
                    state_next    = S_RB;
                end else if (s_valid) begin
                    idx_next    = s_element_index;
                    op_add_next = (s_func == mps_pkg::FUNC_ADD);
                    mark_next   = s_mark_right_end;
                    val_next    = s_add_value;
                    case (s_func)
                        mps_pkg::FUNC_CLEAR: begin
                            clr_row_next  = '0;
                            clr_item_next = 1'b1;
                            state_next    = S_CLR;
                        end
                        mps_pkg::FUNC_MARK, mps_pkg::FUNC_ADD: begin
                            if (in_range) begin
                                node_idx_next = {1'b1, s_element_index[IDX_W-1:1]};
                                rd_node_next  = {1'b1, s_element_index[IDX_W-1:1]};
                                state_next    = S_LEAF;
                            end else begin
                                state_next = S_DN0;
                            end
                        end
                        default: begin
                            state_next = S_DN0;
                        end
                    endcase
                end
            end
            S_LEAF: begin
                mem_req.leaf_wr_en = idx_reg[0] ? 2'b10 : 2'b01;
                kids_l_next  = mps_pkg::leaf_node(leaf_l_upd,
                                                  {idx_reg[IDX_W-1:1], 1'b0}, count_reg);
                kids_r_next  = mps_pkg::leaf_node(leaf_r_upd,
                                                  {idx_reg[IDX_W-1:1], 1'b1}, count_reg);
                rd_node_next = node_idx_reg >> 1;
                state_next   = S_UP0;
            end
            S_UP0: begin
                if (node_idx_reg == IDX_W'(1)) begin
                    root_min_next = cmb_out.min_pfx;
                    state_next    = S_DN0;
                end else begin
                    node_val_next = cmb_out;
                    state_next    = S_UP;
                end
            end
            S_UP: begin
                // store this node, combine it with its sibling into the parent
                mem_req.int_wr_en = node_idx_reg[0] ? 2'b10 : 2'b01;
                node_idx_next     = node_idx_reg >> 1;
                node_val_next     = cmb_out;
                if (node_idx_reg[IDX_W-1:1] == ROW_W'(1)) begin
                    root_min_next = cmb_out.min_pfx;
                    state_next    = S_DN0;
                end else begin
                    rd_node_next = node_idx_reg >> 2;
                end
            end
            S_DN0: begin
                // row 1 may have been written last cycle, read it again
                rd_node_next = IDX_W'(1);
                cur_min_next = root_min_reg;
                state_next   = S_DN;
            end
            S_DN: begin
                if (rd_node_reg[IDX_W-1]) begin
                    if ({1'b0, leaf_j} >= count_reg) begin
                        loc_next = count_m1[IDX_W-1:0];
                    end else begin
                        loc_next = leaf_j;
                    end
                    state_next = S_RES;
                end else begin
                    rd_node_next = leaf_j;
                    cur_min_next = dir ? rd_kid_r.min_pfx : rd_kid_l.min_pfx;
                end
            end
            S_RES: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next        = 1'b1;
                    m_min_prefix_next   = root_min_reg;
                    m_min_location_next = loc_reg;
                    m_none_marked_next  = (root_min_reg == mps_pkg::INF_VAL);
                    state_next          = S_IDLE;
                end
            end
            S_RB: begin
                if (node_idx_reg == IDX_W'(1)) begin
                    root_min_next = cmb_out.min_pfx;
                    state_next    = S_IDLE;
                end else begin
                    mem_req.int_wr_en   = node_idx_reg[0] ? 2'b10 : 2'b01;
                    mem_req.int_wr_data = cmb_out;
                    node_idx_next       = node_idx_reg - 1'b1;
                    rd_node_next        = node_idx_reg - 1'b1;
                    // node 2 lands in row 1 at the edge that reads row 1
                    state_next = (node_idx_reg == IDX_W'(2)) ? S_RB_GAP : S_RB;
                end
            end
            S_RB_GAP: begin
                state_next = S_RB;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        mem_req.rd_row = rd_node_next[ROW_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLR;
            clr_row_reg  <= '0;
            clr_item_reg <= 1'b0;
            pend_reg     <= 1'b0;
            count_reg    <= CNT_W'(mps_pkg::MAX_ELEMENTS);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_row_reg  <= clr_row_next;
            clr_item_reg <= clr_item_next;
            pend_reg     <= pend_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
        node_idx_reg       <= node_idx_next;
        rd_node_reg        <= rd_node_next;
        idx_reg            <= idx_next;
        op_add_reg         <= op_add_next;
        mark_reg           <= mark_next;
        val_reg            <= val_next;
        kids_l_reg         <= kids_l_next;
        kids_r_reg         <= kids_r_next;
        node_val_reg       <= node_val_next;
        root_min_reg       <= root_min_next;
        cur_min_reg        <= cur_min_next;
        loc_reg            <= loc_next;
        m_min_prefix_reg   <= m_min_prefix_next;
        m_min_location_reg <= m_min_location_next;
        m_none_marked_reg  <= m_none_marked_next;
    end

    assign s_ready        = (state_reg == S_IDLE) && !pend_reg;
    assign m_valid        = m_valid_reg;
    assign m_min_prefix   = m_min_prefix_reg;
    assign m_min_location = m_min_location_reg;
    assign m_none_marked  = m_none_marked_reg;

endmodule
